// File: rtl/flat_json_pair_tokenizer_defines.svh
// Assertion macros for the flat JSON pair tokenizer.
`ifndef FLAT_JSON_PAIR_TOKENIZER_DEFINES_SVH
`define FLAT_JSON_PAIR_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define FJPT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("flat_json_pair_tokenizer: check failed");
// Next-cycle implication, checked outside reset.
`define FJPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("flat_json_pair_tokenizer: check failed");
`else
`define FJPT_ASSERT_IMP(lbl, ante, cons)
`define FJPT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/fjpt_pkg.sv
// Types, byte codes and helpers shared by the tokenizer modules.
package fjpt_pkg;

  // Scan phases
  typedef enum logic [2:0] {
    PH_SEEK_KEY   = 3'd0,
    PH_KEY        = 3'd1,
    PH_SEEK_VALUE = 3'd2,
    PH_NUMBER     = 3'd3,
    PH_STRING     = 3'd4,
    PH_BRACKET    = 3'd5
  } phase_t;

  // Byte roles
  typedef enum logic [1:0] {
    ROLE_SKIP  = 2'd0,
    ROLE_KEY   = 2'd1,
    ROLE_VALUE = 2'd2
  } role_t;

  // Per-byte result flags
  typedef struct packed {
    role_t role;
    logic  key_begins;
    logic  pair_complete;
    logic  nesting_overflow;
  } flags_t;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_LBRACK    = 8'h5B;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK    = 8'h5D;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;

  // Digit or one of the signs + - .
  function automatic logic is_number_char(input logic [7:0] b);
    return ((b >= CH_ZERO) && (b <= CH_NINE)) || (b == CH_MINUS) ||
           (b == CH_PLUS) || (b == CH_DOT);
  endfunction

endpackage

// File: rtl/fjpt_scan.sv
// Scan state registers and the per-byte phase update.
module fjpt_scan
  import fjpt_pkg::*;
#(
  parameter int MAX_NESTING = 255,
  localparam int DepthW = $clog2(MAX_NESTING + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [7:0]        text_byte,
  input  logic              end_of_text,
  output flags_t            flags,
  output phase_t            phase,
  output logic [DepthW-1:0] depth
);

  localparam logic [DepthW-1:0] DepthMax = DepthW'(MAX_NESTING);
  localparam logic [DepthW-1:0] DepthOne = DepthW'(1);

  logic              brace;
  logic              prior_bs;
  phase_t            phase_next;
  logic              brace_next;
  logic [DepthW-1:0] depth_next;
  logic              prior_bs_next;

  // Hold state; advance it when an item passes to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_SEEK_KEY;
      brace    <= 1'b0;
      depth    <= '0;
      prior_bs <= 1'b0;
    end else if (advance) begin
      phase    <= phase_next;
      brace    <= brace_next;
      depth    <= depth_next;
      prior_bs <= prior_bs_next;
    end
  end

  // Classify the byte and compute the next state
  always_comb begin
    phase_t            ph_eff;
    logic [7:0]        open_ch;
    logic [7:0]        close_ch;
    logic [DepthW-1:0] dec;
    flags           = '{role: ROLE_SKIP, key_begins: 1'b0, pair_complete: 1'b0,
                        nesting_overflow: 1'b0};
    phase_next      = phase;
    brace_next      = brace;
    depth_next      = depth;
    prior_bs_next   = prior_bs;
    ph_eff          = phase;
    open_ch         = brace ? CH_LBRACE : CH_LBRACK;
    close_ch        = brace ? CH_RBRACE : CH_RBRACK;
    dec             = (depth != '0) ? depth - DepthOne : depth;

    // A number ends before a byte that is not part of it
    if (phase == PH_NUMBER) begin
      if (is_number_char(text_byte)) begin
        flags.role = ROLE_VALUE;
      end else begin
        flags.pair_complete = 1'b1;
        ph_eff              = PH_SEEK_KEY;
      end
    end

    unique case (ph_eff)
      PH_NUMBER: begin
      end
      PH_KEY: begin
        if (text_byte == CH_QUOTE) begin
          phase_next = PH_SEEK_VALUE;
        end else begin
          flags.role = ROLE_KEY;
        end
      end
      PH_SEEK_VALUE: begin
        if ((text_byte == CH_LBRACE) || (text_byte == CH_LBRACK)) begin
          flags.role = ROLE_VALUE;
          brace_next = (text_byte == CH_LBRACE);
          depth_next = DepthOne;
          phase_next = PH_BRACKET;
        end else if (is_number_char(text_byte)) begin
          flags.role = ROLE_VALUE;
          phase_next = PH_NUMBER;
        end else if (text_byte == CH_QUOTE) begin
          flags.role    = ROLE_VALUE;
          prior_bs_next = 1'b0;
          phase_next    = PH_STRING;
        end
      end
      PH_STRING: begin
        flags.role = ROLE_VALUE;
        if ((text_byte == CH_QUOTE) && !prior_bs) begin
          flags.pair_complete = 1'b1;
          phase_next          = PH_SEEK_KEY;
        end
        prior_bs_next = (text_byte == CH_BACKSLASH);
      end
      PH_BRACKET: begin
        flags.role = ROLE_VALUE;
        if (text_byte == open_ch) begin
          if (depth == DepthMax) begin
            flags.nesting_overflow = 1'b1;
          end else begin
            depth_next = depth + DepthOne;
          end
        end else if (text_byte == close_ch) begin
          depth_next = dec;
          if (dec == '0) begin
            flags.pair_complete = 1'b1;
            phase_next          = PH_SEEK_KEY;
          end
        end
      end
      default: begin
        // Seeking a key, also right after a number ended
        phase_next = PH_SEEK_KEY;
        if (text_byte == CH_QUOTE) begin
          flags.key_begins = 1'b1;
          phase_next       = PH_KEY;
        end
      end
    endcase

    // Close any open pair on the last byte and return to reset state
    if (end_of_text) begin
      if (phase_next != PH_SEEK_KEY) begin
        flags.pair_complete = 1'b1;
      end
      phase_next    = PH_SEEK_KEY;
      brace_next    = 1'b0;
      depth_next    = '0;
      prior_bs_next = 1'b0;
    end
  end

endmodule

// File: rtl/flat_json_pair_tokenizer.sv
// From input accept to result valid, each byte passes the input register, then the result register.
// Throughput: one byte per cycle; the scan phase update fits between the two registers.
// Back-pressure on the result side stalls both stages; no bubbles otherwise.
// Reset (rst, synchronous): both stages empty, scan state back to seeking a key.
// Tagging of each byte depends only on the scan state left by the byte before.
`include "flat_json_pair_tokenizer_defines.svh"
// Top level: input register, scan stage and result register of the tokenizer.
module flat_json_pair_tokenizer
  import fjpt_pkg::*;
#(
  parameter int MAX_NESTING = 255
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] byte_role,
  output logic       key_begins,
  output logic       pair_complete,
  output logic       nesting_overflow,
  output logic       final_byte
);

  localparam int DepthW = $clog2(MAX_NESTING + 1);

  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              s1_last;
  logic              out_free;
  logic              s1_adv;
  flags_t            flags;
  phase_t            phase;
  logic [DepthW-1:0] depth;

  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_valid && out_free;
  assign in_ready = !s1_valid || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= text_byte;
      s1_last <= end_of_text;
    end
  end

  fjpt_scan #(
    .MAX_NESTING(MAX_NESTING)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .advance    (s1_adv),
    .text_byte  (s1_byte),
    .end_of_text(s1_last),
    .flags      (flags),
    .phase      (phase),
    .depth      (depth)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_byte         <= s1_byte;
      byte_role        <= flags.role;
      key_begins       <= flags.key_begins;
      pair_complete    <= flags.pair_complete;
      nesting_overflow <= flags.nesting_overflow;
      final_byte       <= s1_last;
    end
  end

  // Checks
  `FJPT_ASSERT_NEXT(a_last_resets_state, s1_adv && s1_last, (phase == PH_SEEK_KEY) && (depth == '0))
  `FJPT_ASSERT_IMP(a_depth_bounded, 1'b1, depth <= DepthW'(MAX_NESTING))
  `FJPT_ASSERT_IMP(a_ovf_is_value, out_valid && nesting_overflow, byte_role == ROLE_VALUE)
  `FJPT_ASSERT_IMP(a_key_quote, out_valid && key_begins, (out_byte == CH_QUOTE) && (byte_role == ROLE_SKIP))

endmodule

// File: sim/flat_json_pair_tokenizer_tb.sv
// Testbench for the flat JSON pair tokenizer: byte tagging checked against a scan-state predictor.
`timescale 1ns / 1ps

module flat_json_pair_tokenizer_tb
  import fjpt_pkg::*;
();

  localparam int NEST_MAX = 255;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam string NUM_CHARS = "0123456789+-.";

  // Expected tagging of one byte
  typedef struct packed {
    logic [7:0] data;
    role_t      role;
    logic       kbeg;
    logic       done;
    logic       ovf;
    logic       last;
  } tag_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] text_byte = 8'h00;
  logic       end_of_text = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] byte_role;
  logic       key_begins;
  logic       pair_complete;
  logic       nesting_overflow;
  logic       final_byte;

  // Predictor scan state
  phase_t scan_ph;
  logic   span_brace;
  int     span_depth;
  logic   esc_prev;

  tag_t       tags_due[$];
  tag_t       tag_exp;
  logic [7:0] text_buf[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int errors = 0;
  int items_sent = 0;
  int texts_sent = 0;
  int results_seen = 0;
  int pairs_closed = 0;
  int overflows_seen = 0;
  int input_stalls = 0;

  flat_json_pair_tokenizer #(
    .MAX_NESTING(NEST_MAX)
  ) i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .text_byte       (text_byte),
    .end_of_text     (end_of_text),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .byte_role       (byte_role),
    .key_begins      (key_begins),
    .pair_complete   (pair_complete),
    .nesting_overflow(nesting_overflow),
    .final_byte      (final_byte)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Digit or one of the number signs
  function automatic logic is_numeric(input logic [7:0] b);
    return (b >= CH_ZERO && b <= CH_NINE) || b == CH_PLUS || b == CH_MINUS || b == CH_DOT;
  endfunction

  function automatic void reset_scan();
    scan_ph = PH_SEEK_KEY;
    span_brace = 1'b0;
    span_depth = 0;
    esc_prev = 1'b0;
  endfunction

  // Append one byte to the text under construction
  function automatic void buf_append(input logic [7:0] b);
    text_buf.insert(text_buf.size(), b);
  endfunction

  // Tag one byte and advance the scan state
  function automatic tag_t tag_byte(input logic [7:0] b, input logic last);
    tag_t       t;
    phase_t     ph;
    logic [7:0] opener;
    logic [7:0] closer;
    t = '{data: b, role: ROLE_SKIP, kbeg: 1'b0, done: 1'b0, ovf: 1'b0, last: last};
    ph = scan_ph;
    // A number ends before a byte that cannot extend it
    if (ph == PH_NUMBER) begin
      if (is_numeric(b)) begin
        t.role = ROLE_VALUE;
      end else begin
        t.done = 1'b1;
        ph = PH_SEEK_KEY;
      end
    end
    case (ph)
      PH_NUMBER: begin
      end
      PH_KEY: begin
        if (b == CH_QUOTE) scan_ph = PH_SEEK_VALUE;
        else t.role = ROLE_KEY;
      end
      PH_SEEK_VALUE: begin
        if (b == CH_LBRACE || b == CH_LBRACK) begin
          t.role = ROLE_VALUE;
          span_brace = (b == CH_LBRACE);
          span_depth = 1;
          scan_ph = PH_BRACKET;
        end else if (is_numeric(b)) begin
          t.role = ROLE_VALUE;
          scan_ph = PH_NUMBER;
        end else if (b == CH_QUOTE) begin
          t.role = ROLE_VALUE;
          esc_prev = 1'b0;
          scan_ph = PH_STRING;
        end
      end
      PH_STRING: begin
        t.role = ROLE_VALUE;
        if (b == CH_QUOTE && !esc_prev) begin
          t.done = 1'b1;
          scan_ph = PH_SEEK_KEY;
        end
        esc_prev = (b == CH_BACKSLASH);
      end
      PH_BRACKET: begin
        opener = span_brace ? CH_LBRACE : CH_LBRACK;
        closer = span_brace ? CH_RBRACE : CH_RBRACK;
        t.role = ROLE_VALUE;
        if (b == opener) begin
          if (span_depth >= NEST_MAX) begin
            span_depth = NEST_MAX;
            t.ovf = 1'b1;
          end else begin
            span_depth++;
          end
        end else if (b == closer) begin
          if (span_depth > 0) span_depth--;
          if (span_depth == 0) begin
            t.done = 1'b1;
            scan_ph = PH_SEEK_KEY;
          end
        end
      end
      default: begin
        scan_ph = PH_SEEK_KEY;
        if (b == CH_QUOTE) begin
          t.kbeg = 1'b1;
          scan_ph = PH_KEY;
        end
      end
    endcase
    // Close any open pair on the final byte
    if (last) begin
      if (scan_ph != PH_SEEK_KEY) t.done = 1'b1;
      reset_scan();
    end
    return t;
  endfunction

  // Offer one item, hold it until accepted, then record its expected tag
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= b;
    end_of_text <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tags_due.insert(tags_due.size(), tag_byte(b, last));
    items_sent++;
    if (last) texts_sent++;
  endtask

  task automatic send_string(input string s, input logic last_on_end);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], last_on_end && (i == s.len() - 1));
    end
  endtask

  task automatic send_buffer();
    foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == CH_QUOTE) b = CH_SPACE;
    return b;
  endfunction

  // Build one text: mostly well-formed pairs with random content, some noise
  task automatic build_random_text();
    int         pairs;
    int         depth;
    int         r;
    int         cut;
    logic       brace;
    logic [7:0] opener;
    logic [7:0] closer;
    text_buf.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 12)) buf_append(8'($urandom_range(255)));
      return;
    end
    pairs = $urandom_range(1, 4);
    repeat (pairs) begin
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 2)) buf_append(plain_byte());
      end
      // key
      buf_append(CH_QUOTE);
      repeat ($urandom_range(0, 6)) buf_append(plain_byte());
      buf_append(CH_QUOTE);
      buf_append(CH_COLON);
      if ($urandom_range(1)) buf_append(CH_SPACE);
      // value
      case ($urandom_range(9))
        0: begin
        end
        1, 2, 3: begin
          repeat ($urandom_range(1, 5)) buf_append(NUM_CHARS[$urandom_range(12)]);
        end
        4, 5, 6: begin
          buf_append(CH_QUOTE);
          repeat ($urandom_range(0, 8)) begin
            if ($urandom_range(9) < 2) begin
              buf_append(CH_BACKSLASH);
              buf_append(8'($urandom_range(255)));
            end else begin
              buf_append(plain_byte());
            end
          end
          buf_append(CH_QUOTE);
        end
        default: begin
          brace = 1'($urandom_range(1));
          opener = brace ? CH_LBRACE : CH_LBRACK;
          closer = brace ? CH_RBRACE : CH_RBRACK;
          buf_append(opener);
          depth = 1;
          repeat ($urandom_range(2, 10)) begin
            r = $urandom_range(9);
            if (r < 3 && depth < 6) begin
              buf_append(opener);
              depth++;
            end else if (r < 5 && depth > 1) begin
              buf_append(closer);
              depth--;
            end else if (r == 5) begin
              // the other kind of bracket is not counted
              case ($urandom_range(1))
                0: buf_append(brace ? CH_LBRACK : CH_LBRACE);
                default: buf_append(brace ? CH_RBRACK : CH_RBRACE);
              endcase
            end else begin
              buf_append(plain_byte());
            end
          end
          repeat (depth) buf_append(closer);
        end
      endcase
      if ($urandom_range(9) < 7) buf_append(CH_COMMA);
    end
    // Break off some texts mid-pair
    if ($urandom_range(9) == 0) begin
      cut = $urandom_range(1, text_buf.size());
      text_buf = text_buf[0:cut-1];
    end
  endtask

  // Drive the receiver: long hold-off when asked, random stalls otherwise
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic check_field(input string what, input logic [7:0] exp, input logic [7:0] act);
    if (act !== exp) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp, act);
      errors++;
    end
  endtask

  // Compare each accepted result with the oldest expected tag
  always @(posedge clk) begin
    if (!rst && in_valid && !in_ready) input_stalls++;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pair_complete === 1'b1) pairs_closed++;
      if (nesting_overflow === 1'b1) overflows_seen++;
      if (tags_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got byte %0h", $time, out_byte);
        errors++;
      end else begin
        tag_exp = tags_due.pop_front();
        check_field("out_byte", tag_exp.data, out_byte);
        check_field("byte_role", 8'(tag_exp.role), 8'(byte_role));
        check_field("key_begins", 8'(tag_exp.kbeg), 8'(key_begins));
        check_field("pair_complete", 8'(tag_exp.done), 8'(pair_complete));
        check_field("nesting_overflow", 8'(tag_exp.ovf), 8'(nesting_overflow));
        check_field("final_byte", 8'(tag_exp.last), 8'(final_byte));
      end
    end
  end

  // Field extremes, every value kind and the special cases
  task automatic test_directed_pairs();
    send_string("\"", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    // number ended by a quote that opens the next key, then a brace span
    send_string("\":+09.-\"k\":{[{}}", 1'b0);
    // empty key, string with escaped quote and escaped backslash
    send_string("\"\"\"\\\"\\\\\"\"", 1'b0);
    // empty key opened by the final byte
    send_string("\"", 1'b1);
    // number cut off by the end of text
    send_string("\"n\":7", 1'b1);
  endtask

  // Drive the bracket depth into saturation, then unwind
  task automatic test_depth_saturation();
    send_string("\"d\":[", 1'b0);
    repeat (NEST_MAX + 1) send_byte(CH_LBRACK, 1'b0);
    repeat (NEST_MAX) send_byte(CH_RBRACK, 1'b0);
    send_byte(CH_RBRACK, 1'b1);
  endtask

  // Hold off the receiver while items keep coming so the block fills up
  task automatic test_output_holdoff();
    int start;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 300;
    start = items_sent;
    while (items_sent - start < 100) begin
      build_random_text();
      send_buffer();
    end
  endtask

  task automatic test_random_texts(input int n, input int s_pct, input int r_pct);
    int start;
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    start = items_sent;
    while (items_sent - start < n) begin
      build_random_text();
      send_buffer();
    end
  endtask

  initial begin
    int guard;
    reset_scan();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_pairs();
    test_depth_saturation();
    test_output_holdoff();
    test_random_texts(130, 0, 0);
    test_random_texts(130, 50, 0);
    test_random_texts(130, 0, 50);
    test_random_texts(130, 35, 35);

    // Drain the pipeline
    in_valid <= 1'b0;
    guard = 0;
    while (tags_due.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (tags_due.size() != 0) begin
      $display("%0t: timeout with %0d results outstanding", $time, tags_due.size());
      $display("flat_json_pair_tokenizer test failed");
      $finish;
    end else begin
      repeat (10) @(posedge clk);
      $display("Tagged %0d bytes in %0d texts, %0d results checked, %0d pairs closed,",
               items_sent, texts_sent, results_seen, pairs_closed);
      $display("%0d depth overflows, %0d cycles of input stall, %0d mismatches.",
               overflows_seen, input_stalls, errors);
      if (errors == 0) begin
        $display("flat_json_pair_tokenizer test passed");
      end else begin
        $display("flat_json_pair_tokenizer test failed");
      end
      $finish;
    end
  end

  // Overall watchdog
  initial begin
    #5_000_000;
    $display("%0t: watchdog expired", $time);
    $display("flat_json_pair_tokenizer test failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/fjpt_pkg.sv
rtl/fjpt_scan.sv
rtl/flat_json_pair_tokenizer.sv
sim/flat_json_pair_tokenizer_tb.sv
